[rtl/lia_pkg.sv]
// ----------------------------------------------------------------------------
// lia_pkg
// Shared widths, codes and field types for the lazily initialized array.
// ----------------------------------------------------------------------------
package lia_pkg;

  localparam int IDX_W     = 10;  // array index field
  localparam int DATA_W    = 32;  // value fields and config data
  localparam int SIZE_W    = 11;  // size_in_use register

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

  typedef enum logic {
    REG_DEFAULT_VALUE = 1'b0,
    REG_SIZE_IN_USE   = 1'b1
  } cfg_reg_t;

endpackage

[rtl/lia_if.sv]
// ----------------------------------------------------------------------------
// lia_if
// Valid/ready channels of the lazily initialized array: config, item, result.
// ----------------------------------------------------------------------------
interface lia_cfg_if;
  logic                         valid;
  logic                         ready;
  lia_pkg::cfg_reg_t            reg_idx;
  logic [lia_pkg::DATA_W-1:0]   data;

  modport source (output valid, output reg_idx, output data, input ready);
  modport sink   (input valid, input reg_idx, input data, output ready);
endinterface

interface lia_in_if;
  logic                              valid;
  logic                              ready;
  lia_pkg::func_t                    func;
  logic [lia_pkg::IDX_W-1:0]         index;
  logic signed [lia_pkg::DATA_W-1:0] write_value;

  modport source (output valid, output func, output index, output write_value, input ready);
  modport sink   (input valid, input func, input index, input write_value, output ready);
endinterface

interface lia_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lia_pkg::DATA_W-1:0] read_value;
  lia_pkg::status_t                  status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink   (input valid, input read_value, input status, output ready);
endinterface

[rtl/lazy_initialized_array_top.sv]
// Flow: an item beat is followed by the pointer memory read, then the dependent
//   pair memory read at the pointer it returns, then the result register; a new
//   item is taken while the last one's result is written.
// Reset: synchronous, active high; clears the fill count, control and config
//   registers. Memories are never cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// lazy_initialized_array_top
// Array with constant-time init: pointer memory maps index to slot, pair
// memory holds owner index and value per slot, fill count marks used slots.
// ----------------------------------------------------------------------------
module lazy_initialized_array_top #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  lia_cfg_if.sink         cfg,
  lia_in_if.sink          item_in,
  lia_out_if.source       result_out
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PAIR_W = lia_pkg::IDX_W + VALUE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE
  } state_t;

  state_t state;

  // config registers
  logic [lia_pkg::DATA_W-1:0]  default_q;
  logic [lia_pkg::SIZE_W-1:0]  size_in_use;

  // memories
  logic [PTR_W-1:0]  ptr_mem  [DEPTH];
  logic [PAIR_W-1:0] pair_mem [DEPTH];

  logic [PTR_W-1:0]  ptr_rdata;
  logic [PAIR_W-1:0] pair_rdata;

  // item in flight
  lia_pkg::func_t              func_q;
  logic [lia_pkg::IDX_W-1:0]   idx_q;
  logic [lia_pkg::DATA_W-1:0]  wv_q;
  logic [PTR_W-1:0]            slot_q;
  logic                        fwd_hit;
  logic                        fwd_set;
  logic [PTR_W-1:0]            fwd_ptr;
  logic [CNT_W-1:0]            slots_used;

  // result register
  logic                        out_valid;
  logic [lia_pkg::DATA_W-1:0]  out_value;
  lia_pkg::status_t            out_status;

  logic                        accept;
  logic                        can_finish;
  logic [PTR_W-1:0]            slot_addr;
  logic                        in_range;
  logic                        entry_hit;
  logic                        can_alloc;
  logic [lia_pkg::IDX_W-1:0]   owner_idx;
  logic [VALUE_WIDTH-1:0]      slot_val;
  logic [VALUE_WIDTH-1:0]      wv_fit;
  logic [VALUE_WIDTH-1:0]      dflt_fit;

  assign can_finish     = !out_valid || result_out.ready;
  assign item_in.ready  = !rst && ((state == S_IDLE) || ((state == S_DECIDE) && can_finish));
  assign accept         = item_in.valid && item_in.ready;
  assign cfg.ready      = !rst;

  assign result_out.valid      = out_valid;
  assign result_out.read_value = out_value;
  assign result_out.status     = out_status;

  // a pointer written on the cycle of the next beat is not yet visible in the read
  assign slot_addr = fwd_hit ? fwd_ptr : ptr_rdata;

  assign owner_idx = pair_rdata[PAIR_W-1 -: lia_pkg::IDX_W];
  assign slot_val  = pair_rdata[VALUE_WIDTH-1:0];
  assign wv_fit    = VALUE_WIDTH'(wv_q);
  assign dflt_fit  = VALUE_WIDTH'(default_q);

  assign in_range  = (int'(idx_q) < int'(size_in_use)) && (int'(idx_q) < DEPTH);
  assign entry_hit = (CNT_W'(slot_q) < slots_used) && (owner_idx == idx_q);
  assign can_alloc = slots_used < CNT_W'(DEPTH);

  // next beat targets the index whose slot is being claimed this cycle
  always_comb begin
    fwd_set = 1'b0;
    if ((state == S_DECIDE) && in_range && (func_q == lia_pkg::FUNC_WRITE)) begin
      if (entry_hit) begin
        fwd_set = 1'b0;
      end else if (can_alloc) begin
        fwd_set = (item_in.index == idx_q);
      end
    end
  end

  // pointer memory read, addressed straight from the input beat
  always_ff @(posedge clk) begin
    ptr_rdata <= ptr_mem[PTR_W'(item_in.index)];
  end

  // pair memory read at the pointer; held while the result waits
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      pair_rdata <= pair_mem[slot_addr];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      default_q   <= '0;
      size_in_use <= lia_pkg::SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_idx)
        lia_pkg::REG_DEFAULT_VALUE: default_q   <= cfg.data;
        lia_pkg::REG_SIZE_IN_USE:   size_in_use <= cfg.data[lia_pkg::SIZE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= '0;
      out_valid  <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if ((state == S_DECIDE) && can_finish) begin
        out_valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        func_q  <= item_in.func;
        idx_q   <= item_in.index;
        wv_q    <= item_in.write_value;
        fwd_hit <= fwd_set;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          slot_q <= slot_addr;
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          if (can_finish) begin
            if (!in_range) begin
              out_status <= lia_pkg::STATUS_RANGE;
              out_value  <= (func_q == lia_pkg::FUNC_WRITE) ? '0
                                                           : lia_pkg::DATA_W'(dflt_fit);
            end else if (func_q == lia_pkg::FUNC_READ) begin
              out_status <= lia_pkg::STATUS_OK;
              if (entry_hit) begin
                out_value <= lia_pkg::DATA_W'(slot_val);
              end else begin
                out_value <= lia_pkg::DATA_W'(dflt_fit);
              end
            end else begin
              out_status <= lia_pkg::STATUS_OK;
              out_value  <= '0;
              if (entry_hit) begin
                pair_mem[slot_q] <= {idx_q, wv_fit};
              end else if (can_alloc) begin
                // claim the next free slot
                pair_mem[PTR_W'(slots_used)]    <= {idx_q, wv_fit};
                ptr_mem[PTR_W'(idx_q)]          <= PTR_W'(slots_used);
                slots_used                      <= slots_used + CNT_W'(1);
                if (accept && (item_in.index == idx_q)) begin
                  fwd_ptr <= PTR_W'(slots_used);
                end
              end
            end
            state <= accept ? S_LOOK : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lia_checker.sv]
// ----------------------------------------------------------------------------
// lia_checker
// Port-level checks on the lazily initialized array, bound to the top level.
// ----------------------------------------------------------------------------
module lia_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lia_pkg::DATA_W-1:0]  out_value,
  input logic                        out_status
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // two memory reads per item: never two item beats in a row
  a_item_spacing: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_beat)
    else $error("item beats on consecutive cycles");

  // a fresh result traces back to its item beat through the pointer read, the pair read and the result register
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_beat, 3))
    else $error("result without matching item beat");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind lazy_initialized_array_top lia_checker u_lia_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item_in.valid),
  .in_ready   (item_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_value  (result_out.read_value),
  .out_status (result_out.status)
);
